@@ rtl/lts_pkg.sv @@
// shared types, codes and saturating helpers for the latency statistics block
package lts_pkg;

    localparam int CNT_W     = 32;
    localparam int SUM_W     = 48;
    localparam int DELAY_W   = 32;
    localparam int THR_W     = 16;
    localparam int TYPE_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;
    localparam int MAX_SLOTS = 4;
    localparam int IN_W      = 40;
    localparam int OUT_W     = 360;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // reset values: 10 ms low and 50 ms high in every lane
    localparam logic [CFG_W-1:0] THR_LOW_RESET  = {4{16'd10}};
    localparam logic [CFG_W-1:0] THR_HIGH_RESET = {4{16'd50}};

    typedef enum logic {
        FUNC_RECORD = 1'b0,
        FUNC_READ   = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        BAND_BELOW = 2'd0,
        BAND_LOW   = 2'd1,
        BAND_HIGH  = 2'd2,
        BAND_NONE  = 2'd3
    } t_band;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE  = 3'd0,
        CFG_TRIGGER = 3'd1,
        CFG_ACTION  = 3'd2,
        CFG_LOW_THR = 3'd3,
        CFG_HIGH_THR = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [CNT_W-1:0] low_count;
        logic [CNT_W-1:0] high_count;
        logic [SUM_W-1:0] delay_sum;
        logic [CNT_W-1:0] sample_count;
        logic [CNT_W-1:0] fg_low_count;
        logic [CNT_W-1:0] fg_high_count;
        logic [SUM_W-1:0] fg_delay_sum;
        logic [CNT_W-1:0] fg_sample_count;
        logic [CNT_W-1:0] fg_max_delay;
        logic [CNT_W-1:0] last_delay;
    } t_entry;

    // control for one update pass
    typedef struct packed {
        logic record;     // record word on a present, enabled type
        logic fg;         // foreground sample
        logic alert_arm;  // trigger bit, action enable and alert type all match
    } t_upd_ctl;

    function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
    endfunction

    function automatic logic [SUM_W-1:0] add_sat(input logic [SUM_W-1:0] s,
                                                 input logic [DELAY_W-1:0] d);
        logic [SUM_W:0] r;
        r = {1'b0, s} + (SUM_W+1)'(d);
        return r[SUM_W] ? SUM_MAX : r[SUM_W-1:0];
    endfunction

endpackage

@@ rtl/lts_update.sv @@
// classifies one delay and computes the updated statistics entry
module lts_update (
    input  lts_pkg::t_entry                 i_entry,
    input  lts_pkg::t_upd_ctl               i_ctl,
    input  logic [lts_pkg::DELAY_W-1:0]     i_delay,
    input  logic [lts_pkg::THR_W-1:0]       i_thr_low,
    input  logic [lts_pkg::THR_W-1:0]       i_thr_high,
    output lts_pkg::t_entry                 o_entry,
    output lts_pkg::t_band                  o_band,
    output logic                            o_alert
);

    logic is_high;
    logic is_low;

    assign is_high = i_delay >= lts_pkg::DELAY_W'(i_thr_high);
    assign is_low  = i_delay >= lts_pkg::DELAY_W'(i_thr_low);

    always_comb begin
        o_entry = i_entry;
        o_band  = lts_pkg::BAND_NONE;
        o_alert = 1'b0;
        if (i_ctl.record) begin
            if (i_ctl.fg) begin
                o_entry.fg_delay_sum    = lts_pkg::add_sat(i_entry.fg_delay_sum, i_delay);
                o_entry.fg_sample_count = lts_pkg::inc_sat(i_entry.fg_sample_count);
                if (i_delay > i_entry.fg_max_delay) begin
                    o_entry.fg_max_delay = i_delay;
                end
            end
            // high test first, so crossed thresholds leave the low band empty
            if (is_high) begin
                o_band             = lts_pkg::BAND_HIGH;
                o_entry.high_count = lts_pkg::inc_sat(i_entry.high_count);
                if (i_ctl.fg) begin
                    o_entry.fg_high_count = lts_pkg::inc_sat(i_entry.fg_high_count);
                    o_alert               = i_ctl.alert_arm;
                end
            end else if (is_low) begin
                o_band            = lts_pkg::BAND_LOW;
                o_entry.low_count = lts_pkg::inc_sat(i_entry.low_count);
                if (i_ctl.fg) begin
                    o_entry.fg_low_count = lts_pkg::inc_sat(i_entry.fg_low_count);
                end
            end else begin
                o_band = lts_pkg::BAND_BELOW;
            end
            o_entry.last_delay   = i_delay;
            o_entry.delay_sum    = lts_pkg::add_sat(i_entry.delay_sum, i_delay);
            o_entry.sample_count = lts_pkg::inc_sat(i_entry.sample_count);
        end
    end

endmodule

@@ rtl/latency_threshold_statistics.sv @@
// top level: per-type latency statistics table with stream ports
//
// usage
//   input words arrive on the i_s_* stream: tuser carries the function
//   (record a delay sample or read a type's statistics), tdata the type,
//   the foreground flag and the delay in ms. every input word produces
//   exactly one output word on o_m_* with the type's statistics after
//   the word was applied, plus the band the delay fell in and the alert.
//   thresholds, masks and the alert enable are set over the i_cfg_* write
//   port, by the user only while no word is in flight (not enforced).
// timing
//   two register stages: an input register and the result register. the
//   table read, classification, saturating update and write-back of one
//   entry happen between them, so a word on the same type right behind
//   sees the update with no forwarding needed. o_m_tvalid rises as a word
//   moves from the input register into the result register; with i_m_tready
//   high, one word per cycle is sustained by the single table update.
// reset and stalls
//   a synchronous active-low reset clears all statistics, restores the
//   register defaults and empties both stages. when the receiver holds
//   i_m_tready low the result holds; an empty input register still takes
//   one more word, then o_s_tready drops until the result is taken.
module latency_threshold_statistics #(
    parameter int NUM_TYPES  = 4,
    parameter int ALERT_TYPE = 2
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [lts_pkg::IN_W-1:0]         i_s_tdata,   // stat_type, foreground, delay_ms
    input  logic                             i_s_tuser,   // func
    // output stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // low_count, high_count, total_delay_ms, total_count, fg_low_count,
    // fg_high_count, fg_total_delay_ms, fg_total_count, fg_max_delay_ms,
    // last_delay_ms, band, alert
    output logic [lts_pkg::OUT_W-1:0]        o_m_tdata,
    // register write port
    input  logic                             i_cfg_wen,
    input  logic [lts_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lts_pkg::CFG_W-1:0]        i_cfg_data
);

    // only the first four types are addressable by a 2-bit type field
    localparam int SLOTS  = (NUM_TYPES < lts_pkg::MAX_SLOTS) ? NUM_TYPES : lts_pkg::MAX_SLOTS;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // configuration registers
    logic [lts_pkg::MAX_SLOTS-1:0]   r_cfg_enable;
    logic [lts_pkg::MAX_SLOTS-1:0]   r_cfg_trigger;
    logic                            r_cfg_action;
    logic [lts_pkg::CFG_W-1:0]       r_cfg_low;
    logic [lts_pkg::CFG_W-1:0]       r_cfg_high;

    // input stage
    logic                            r_s1_valid;
    lts_pkg::t_func                  r_s1_func;
    logic [lts_pkg::TYPE_W-1:0]      r_s1_type;
    logic                            r_s1_fg;
    logic [lts_pkg::DELAY_W-1:0]     r_s1_delay;

    // result stage
    logic                            r_out_valid;
    logic [lts_pkg::OUT_W-1:0]       r_out_data;

    // statistics table, one entry per present type
    lts_pkg::t_entry                 r_table [SLOTS];

    logic                            out_free;
    logic                            s1_move;
    logic                            s_accept;
    logic                            present;
    logic [SLOT_W-1:0]               rd_idx;
    lts_pkg::t_entry                 rd_entry;
    lts_pkg::t_upd_ctl               upd_ctl;
    lts_pkg::t_entry                 upd_entry;
    lts_pkg::t_band                  upd_band;
    logic                            upd_alert;
    logic [lts_pkg::THR_W-1:0]       thr_low;
    logic [lts_pkg::THR_W-1:0]       thr_high;

    // handshake: result register frees when taken, input stage moves into it
    assign out_free   = !r_out_valid || i_m_tready;
    assign s1_move    = r_s1_valid && out_free;
    assign o_s_tready = !r_s1_valid || out_free;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // entry lookup; an absent type reads as all zero
    assign present  = 32'(r_s1_type) < NUM_TYPES;
    assign rd_idx   = present ? r_s1_type[SLOT_W-1:0] : '0;
    assign rd_entry = present ? r_table[rd_idx] : '0;

    assign thr_low  = r_cfg_low[{r_s1_type, 4'b0000} +: lts_pkg::THR_W];
    assign thr_high = r_cfg_high[{r_s1_type, 4'b0000} +: lts_pkg::THR_W];

    assign upd_ctl.record    = (r_s1_func == lts_pkg::FUNC_RECORD) && present
                               && r_cfg_enable[r_s1_type];
    assign upd_ctl.fg        = r_s1_fg;
    assign upd_ctl.alert_arm = r_cfg_trigger[r_s1_type] && r_cfg_action
                               && (32'(r_s1_type) == ALERT_TYPE);

    lts_update u_update (
        .i_entry    (rd_entry),
        .i_ctl      (upd_ctl),
        .i_delay    (r_s1_delay),
        .i_thr_low  (thr_low),
        .i_thr_high (thr_high),
        .o_entry    (upd_entry),
        .o_band     (upd_band),
        .o_alert    (upd_alert)
    );

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_enable  <= '1;
            r_cfg_trigger <= '0;
            r_cfg_action  <= 1'b0;
            r_cfg_low     <= lts_pkg::THR_LOW_RESET;
            r_cfg_high    <= lts_pkg::THR_HIGH_RESET;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                lts_pkg::CFG_ENABLE:   r_cfg_enable  <= i_cfg_data[lts_pkg::MAX_SLOTS-1:0];
                lts_pkg::CFG_TRIGGER:  r_cfg_trigger <= i_cfg_data[lts_pkg::MAX_SLOTS-1:0];
                lts_pkg::CFG_ACTION:   r_cfg_action  <= i_cfg_data[0];
                lts_pkg::CFG_LOW_THR:  r_cfg_low     <= i_cfg_data;
                lts_pkg::CFG_HIGH_THR: r_cfg_high    <= i_cfg_data;
                default: ;  // unused indexes are dropped
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_func  <= lts_pkg::t_func'(i_s_tuser);
            r_s1_type  <= i_s_tdata[1:0];
            r_s1_fg    <= i_s_tdata[2];
            r_s1_delay <= i_s_tdata[34:3];
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_data <= {5'b0, upd_alert, upd_band,
                           upd_entry.last_delay, upd_entry.fg_max_delay,
                           upd_entry.fg_sample_count, upd_entry.fg_delay_sum,
                           upd_entry.fg_high_count, upd_entry.fg_low_count,
                           upd_entry.sample_count, upd_entry.delay_sum,
                           upd_entry.high_count, upd_entry.low_count};
        end
    end

    // table write-back, same edge as the result is captured
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_table[i] <= '0;
            end
        end else if (s1_move && upd_ctl.record) begin
            r_table[rd_idx] <= upd_entry;
        end
    end

endmodule

@@ rtl/lts_checker.sv @@
// port-level checks for the latency statistics block and their bind
module lts_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_s_tready,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [lts_pkg::OUT_W-1:0]     o_m_tdata
);

    // a stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled output word changed");

    // input side only backs up when a result waits
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with empty result register");

    // pipeline is empty right after reset
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_m_tvalid && o_s_tready)
        else $error("word present after reset");

    // alert only on a high band record
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[354] |-> o_m_tdata[353:352] == lts_pkg::BAND_HIGH)
        else $error("alert without high band");

    // high count and foreground total count never exceed the total count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[63:32] <= o_m_tdata[143:112]
                       && o_m_tdata[287:256] <= o_m_tdata[143:112])
        else $error("band or foreground count above total count");

endmodule

bind latency_threshold_statistics lts_checker u_lts_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

@@ tb/sv/tb.sv @@
// self-checking testbench for the latency threshold statistics table
`timescale 1ns / 100ps

module tb;

    localparam int N_TYPES = 4;
    localparam int ALERT_T = 2;

    // one input word as the sender sees it
    typedef struct {
        lts_pkg::t_func func;
        logic [1:0]     stype;
        logic           fg;
        logic [31:0]    delay_ms;
    } t_lat_word;

    // result word laid out exactly as o_m_tdata, low_count in the lowest bits
    typedef struct packed {
        logic [4:0]     pad;
        logic           alert;
        lts_pkg::t_band band;
        logic [31:0]    last_delay_ms;
        logic [31:0]    fg_max_delay_ms;
        logic [31:0]    fg_total_count;
        logic [47:0]    fg_total_delay_ms;
        logic [31:0]    fg_high_count;
        logic [31:0]    fg_low_count;
        logic [31:0]    total_count;
        logic [47:0]    total_delay_ms;
        logic [31:0]    high_count;
        logic [31:0]    low_count;
    } t_stats_word;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [lts_pkg::IN_W-1:0]      i_s_tdata = '0;      // stat_type, foreground, delay_ms
    logic                          i_s_tuser = 1'b0;    // func
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    // low_count, high_count, total_delay_ms, total_count, fg_low_count,
    // fg_high_count, fg_total_delay_ms, fg_total_count, fg_max_delay_ms,
    // last_delay_ms, band, alert
    logic [lts_pkg::OUT_W-1:0]     o_m_tdata;
    logic                          i_cfg_wen = 1'b0;
    logic [lts_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [lts_pkg::CFG_W-1:0]     i_cfg_data = '0;

    latency_threshold_statistics #(
        .NUM_TYPES  (N_TYPES),
        .ALERT_TYPE (ALERT_T)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_wen  (i_cfg_wen),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the register file, tracked as it is written
    logic [3:0]                en_mask  = 4'hF;
    logic [3:0]                trig_mask = 4'h0;
    logic                      act_en   = 1'b0;
    logic [lts_pkg::CFG_W-1:0] low_thr  = lts_pkg::THR_LOW_RESET;
    logic [lts_pkg::CFG_W-1:0] high_thr = lts_pkg::THR_HIGH_RESET;

    // shadow statistics table; band, alert and pad are unused here
    t_stats_word type_stats [N_TYPES] = '{default: '0};

    t_lat_word   pending_words_q[$];
    t_stats_word expected_stats_q[$];

    int   n_queued = 0;       // words handed to the sender
    int   n_taken = 0;        // words accepted by the block
    int   n_results = 0;
    int   mismatches = 0;
    bit   in_fire = 1'b0;     // input handshake at the last rising edge
    int   src_gap = 0;
    int   sink_gap = 0;
    bit   src_idle_on = 1'b1;
    bit   sink_idle_on = 1'b1;
    logic hold_on = 1'b0;     // long receiver hold-off, driven by its own process
    t_lat_word   next_word;
    t_stats_word got_word;
    t_stats_word want_word;

    function automatic logic [31:0] bump_count(input logic [31:0] c);
        if (&c)
            return c;
        return c + 32'd1;
    endfunction

    function automatic logic [47:0] accumulate_ms(input logic [47:0] s, input logic [31:0] d);
        logic [48:0] wide;
        wide = 49'(s) + 49'(d);
        return wide[48] ? {48{1'b1}} : wide[47:0];
    endfunction

    // classify one word against the shadow registers, update the shadow
    // table and return the result the block should send for it
    function automatic t_stats_word apply_latency_word(input lts_pkg::t_func fn,
                                                       input logic [1:0] ty,
                                                       input logic fg, input logic [31:0] dly);
        t_stats_word    e;
        logic [15:0]    lo;
        logic [15:0]    hi;
        bit             present;
        lts_pkg::t_band band;
        logic           alert;
        present = int'(ty) < N_TYPES;
        e = present ? type_stats[ty] : '0;
        band = lts_pkg::BAND_NONE;
        alert = 1'b0;
        if (fn == lts_pkg::FUNC_RECORD && present && en_mask[ty]) begin
            lo = low_thr[16*ty +: 16];
            hi = high_thr[16*ty +: 16];
            if (fg) begin
                e.fg_total_delay_ms = accumulate_ms(e.fg_total_delay_ms, dly);
                e.fg_total_count = bump_count(e.fg_total_count);
                if (dly > e.fg_max_delay_ms)
                    e.fg_max_delay_ms = dly;
            end
            // high test first: with crossed thresholds the low band may be empty
            if (dly >= 32'(hi)) begin
                band = lts_pkg::BAND_HIGH;
                e.high_count = bump_count(e.high_count);
                if (fg) begin
                    e.fg_high_count = bump_count(e.fg_high_count);
                    alert = trig_mask[ty] && act_en && int'(ty) == ALERT_T;
                end
            end else if (dly >= 32'(lo)) begin
                band = lts_pkg::BAND_LOW;
                e.low_count = bump_count(e.low_count);
                if (fg)
                    e.fg_low_count = bump_count(e.fg_low_count);
            end else begin
                band = lts_pkg::BAND_BELOW;
            end
            e.last_delay_ms = dly;
            e.total_delay_ms = accumulate_ms(e.total_delay_ms, dly);
            e.total_count = bump_count(e.total_count);
            type_stats[ty] = e;
        end
        e.pad = '0;
        e.band = band;
        e.alert = alert;
        return e;
    endfunction

    task automatic check_field(input string fname, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            if (mismatches < 10)
                $display("result %0d: %s expected %0h, got %0h", n_results, fname, want, got);
            mismatches++;
        end
    endtask

    // monitor: outputs and input handshakes are sampled at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_fire = 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got_word = o_m_tdata;
                if (expected_stats_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("result %0d arrived with nothing outstanding: %h",
                                 n_results, o_m_tdata);
                    mismatches++;
                end else begin
                    want_word = expected_stats_q.pop_front();
                    check_field("low_count", 64'(got_word.low_count),
                                64'(want_word.low_count));
                    check_field("high_count", 64'(got_word.high_count),
                                64'(want_word.high_count));
                    check_field("total_delay_ms", 64'(got_word.total_delay_ms),
                                64'(want_word.total_delay_ms));
                    check_field("total_count", 64'(got_word.total_count),
                                64'(want_word.total_count));
                    check_field("fg_low_count", 64'(got_word.fg_low_count),
                                64'(want_word.fg_low_count));
                    check_field("fg_high_count", 64'(got_word.fg_high_count),
                                64'(want_word.fg_high_count));
                    check_field("fg_total_delay_ms", 64'(got_word.fg_total_delay_ms),
                                64'(want_word.fg_total_delay_ms));
                    check_field("fg_total_count", 64'(got_word.fg_total_count),
                                64'(want_word.fg_total_count));
                    check_field("fg_max_delay_ms", 64'(got_word.fg_max_delay_ms),
                                64'(want_word.fg_max_delay_ms));
                    check_field("last_delay_ms", 64'(got_word.last_delay_ms),
                                64'(want_word.last_delay_ms));
                    check_field("band", 64'(got_word.band), 64'(want_word.band));
                    check_field("alert", 64'(got_word.alert), 64'(want_word.alert));
                    // padding bits must stay zero
                    check_field("pad", 64'(got_word.pad), 64'(want_word.pad));
                end
                n_results++;
            end
            in_fire = i_s_tvalid && o_s_tready;
            if (in_fire) begin
                // predict straight from the bus: tdata is type, fg, delay from bit 0 up
                expected_stats_q.push_back(apply_latency_word(lts_pkg::t_func'(i_s_tuser),
                    i_s_tdata[1:0], i_s_tdata[2], i_s_tdata[34:3]));
                n_taken++;
            end
        end
    end

    // sender: a word stays on the bus until taken, gaps only between words
    always @(negedge i_clk) begin
        if (!i_s_tvalid || in_fire) begin
            if (src_gap > 0) begin
                src_gap--;
                i_s_tvalid <= 1'b0;
            end else if (src_idle_on && pending_words_q.size() > 0 &&
                         $urandom_range(0, 5) == 0) begin
                // start an idle gap, its length drawn at random
                src_gap = $urandom_range(0, 7);
                i_s_tvalid <= 1'b0;
            end else if (pending_words_q.size() > 0) begin
                next_word = pending_words_q.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tuser <= next_word.func;
                i_s_tdata <= {5'd0, next_word.delay_ms, next_word.fg, next_word.stype};
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stall bursts plus the long hold-off
    always @(negedge i_clk) begin
        if (sink_gap > 0) begin
            sink_gap--;
            i_m_tready <= 1'b0;
        end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
            sink_gap = $urandom_range(0, 7);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= !hold_on;
        end
    end

    function automatic t_lat_word make_word(input lts_pkg::t_func fn, input logic [1:0] ty,
                                            input logic fg, input logic [31:0] dly);
        t_lat_word w;
        w.func = fn;
        w.stype = ty;
        w.fg = fg;
        w.delay_ms = dly;
        return w;
    endfunction

    task automatic queue_word(input t_lat_word w);
        pending_words_q.push_back(w);
        n_queued++;
    endtask

    // wait until every word is taken and answered, then let the pipe settle
    task automatic drain();
        while (n_taken != n_queued || expected_stats_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [lts_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lts_pkg::CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wen <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_wen <= 1'b0;
        case (idx)
            lts_pkg::CFG_ENABLE:   en_mask = val[3:0];
            lts_pkg::CFG_TRIGGER:  trig_mask = val[3:0];
            lts_pkg::CFG_ACTION:   act_en = val[0];
            lts_pkg::CFG_LOW_THR:  low_thr = val;
            lts_pkg::CFG_HIGH_THR: high_thr = val;
            default:               ;   // unmapped index, ignored by the block
        endcase
    endtask

    function automatic logic [15:0] pick_lane();
        case ($urandom_range(0, 4))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 300));
            default: return 16'($urandom);
        endcase
    endfunction

    // kind 0: all-zero thresholds, kind 1: all-ones thresholds, else random
    task automatic program_setting(input int kind);
        logic [lts_pkg::CFG_W-1:0] lo;
        logic [lts_pkg::CFG_W-1:0] hi;
        for (int l = 0; l < N_TYPES; l++) begin
            lo[16*l +: 16] = pick_lane();
            hi[16*l +: 16] = pick_lane();
        end
        if (kind == 0) begin
            lo = '0;
            hi = '0;
        end else if (kind == 1) begin
            lo = '1;
            hi = '1;
        end
        write_reg(lts_pkg::CFG_ENABLE, (kind < 2) ? 64'hF : 64'($urandom_range(0, 15) |
                                                               $urandom_range(0, 15)));
        write_reg(lts_pkg::CFG_TRIGGER, 64'($urandom_range(0, 15)));
        write_reg(lts_pkg::CFG_ACTION, 64'(kind % 2 == 0 || $urandom_range(0, 1) == 1));
        write_reg(lts_pkg::CFG_LOW_THR, lo);
        write_reg(lts_pkg::CFG_HIGH_THR, hi);
    endtask

    // random word, delays often sitting on a threshold edge of the chosen type
    function automatic t_lat_word pick_word();
        t_lat_word   w;
        logic [15:0] thr;
        w.func = ($urandom_range(0, 7) == 0) ? lts_pkg::FUNC_READ : lts_pkg::FUNC_RECORD;
        // the alert type gets extra traffic
        w.stype = ($urandom_range(0, 3) == 0) ? 2'(ALERT_T) : 2'($urandom_range(0, 3));
        w.fg = 1'($urandom);
        thr = $urandom_range(0, 1) ? low_thr[16*w.stype +: 16] : high_thr[16*w.stype +: 16];
        case ($urandom_range(0, 9))
            0, 1, 2, 3: w.delay_ms = 32'(thr) + 32'($urandom_range(0, 2)) - 32'd1;
            4, 5:       w.delay_ms = 32'($urandom_range(0, 300));
            6, 7:       w.delay_ms = $urandom;
            8:          w.delay_ms = 32'($urandom_range(0, 65535));
            default:    w.delay_ms = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
        endcase
        return w;
    endfunction

    initial begin
        int ph;
        int k;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset thresholds 10 / 50, no alerts possible yet
        queue_word(make_word(lts_pkg::FUNC_READ, 2'd0, 1'b1, 32'hFFFF_FFFF));
        queue_word(make_word(lts_pkg::FUNC_READ, 2'd3, 1'b0, 32'h0));
        queue_word(make_word(lts_pkg::FUNC_RECORD, 2'd0, 1'b0, 32'd0));
        queue_word(make_word(lts_pkg::FUNC_RECORD, 2'd0, 1'b1, 32'd9));
        queue_word(make_word(lts_pkg::FUNC_RECORD, 2'd0, 1'b1, 32'd10));
        queue_word(make_word(lts_pkg::FUNC_RECORD, 2'd1, 1'b0, 32'd49));
        queue_word(make_word(lts_pkg::FUNC_RECORD, 2'd1, 1'b1, 32'd50));
        queue_word(make_word(lts_pkg::FUNC_RECORD, 2'd3, 1'b1, 32'hFFFF_FFFF));
        queue_word(make_word(lts_pkg::FUNC_RECORD, 2'(ALERT_T), 1'b1, 32'd100));
        queue_word(make_word(lts_pkg::FUNC_READ, 2'd1, 1'b1, 32'd7));
        drain();

        // alerts armed, type 3 disabled, crossed thresholds on type 1,
        // lane extremes on types 0 and 3
        write_reg(lts_pkg::CFG_TRIGGER, 64'hF);
        write_reg(lts_pkg::CFG_ACTION, 64'h1);
        write_reg(lts_pkg::CFG_ENABLE, 64'h7);
        write_reg(lts_pkg::CFG_LOW_THR, {16'hFFFF, 16'd10, 16'd1000, 16'd0});
        write_reg(lts_pkg::CFG_HIGH_THR, {16'hFFFF, 16'd50, 16'd100, 16'hFFFF});
        // unmapped indexes must leave every register alone
        for (k = int'(lts_pkg::CFG_HIGH_THR) + 1; k < 2 ** lts_pkg::CFG_IDX_W; k++)
            write_reg(lts_pkg::CFG_IDX_W'(k), '1);
        queue_word(make_word(lts_pkg::FUNC_RECORD, 2'(ALERT_T), 1'b1, 32'd50));
        queue_word(make_word(lts_pkg::FUNC_RECORD, 2'(ALERT_T), 1'b0, 32'd60));
        queue_word(make_word(lts_pkg::FUNC_RECORD, 2'd1, 1'b1, 32'd500));
        queue_word(make_word(lts_pkg::FUNC_RECORD, 2'd1, 1'b1, 32'd99));
        queue_word(make_word(lts_pkg::FUNC_RECORD, 2'd0, 1'b0, 32'd0));
        queue_word(make_word(lts_pkg::FUNC_RECORD, 2'd0, 1'b1, 32'hFFFF));
        queue_word(make_word(lts_pkg::FUNC_RECORD, 2'd0, 1'b1, 32'hFFFE));
        queue_word(make_word(lts_pkg::FUNC_RECORD, 2'd3, 1'b1, 32'd5));
        queue_word(make_word(lts_pkg::FUNC_READ, 2'd3, 1'b0, 32'd0));
        drain();

        // alert type's trigger bit clear, then the global enable clear
        write_reg(lts_pkg::CFG_TRIGGER, 64'hB);
        queue_word(make_word(lts_pkg::FUNC_RECORD, 2'(ALERT_T), 1'b1, 32'd70));
        drain();
        write_reg(lts_pkg::CFG_TRIGGER, 64'hF);
        write_reg(lts_pkg::CFG_ACTION, 64'h0);
        queue_word(make_word(lts_pkg::FUNC_RECORD, 2'(ALERT_T), 1'b1, 32'd70));
        drain();
        // every type disabled
        write_reg(lts_pkg::CFG_ENABLE, 64'h0);
        queue_word(make_word(lts_pkg::FUNC_RECORD, 2'd1, 1'b1, 32'd200));
        queue_word(make_word(lts_pkg::FUNC_RECORD, 2'(ALERT_T), 1'b1, 32'hFFFF_FFFF));
        drain();

        // random phases, each with its own register setting
        for (ph = 0; ph < 7; ph++) begin
            program_setting(ph);
            src_idle_on = (ph % 3) != 2;
            sink_idle_on = (ph % 3) != 2;
            for (k = 0; k < 120; k++)
                queue_word(pick_word());
            if (ph == 1) begin
                // receiver holds off while the sender keeps offering,
                // so the block fills and drops o_s_tready
                fork
                    begin
                        @(posedge i_clk);
                        hold_on = 1'b1;
                        repeat (120) @(posedge i_clk);
                        hold_on = 1'b0;
                    end
                join_none
            end
            if (ph == 3)
                drain();   // sender pauses until the pipe is empty
            for (k = 0; k < 120; k++)
                queue_word(pick_word());
            drain();
        end

        // last part, no idling: back-to-back large delays on one type
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        write_reg(lts_pkg::CFG_ENABLE, 64'hF);
        write_reg(lts_pkg::CFG_TRIGGER, 64'hF);
        write_reg(lts_pkg::CFG_ACTION, 64'h1);
        write_reg(lts_pkg::CFG_LOW_THR, lts_pkg::THR_LOW_RESET);
        write_reg(lts_pkg::CFG_HIGH_THR, lts_pkg::THR_HIGH_RESET);
        for (k = 0; k < 20; k++)
            queue_word(make_word(lts_pkg::FUNC_RECORD, 2'd3, 1'b1, 32'hFFFF_FFFF));
        for (k = 0; k < N_TYPES; k++)
            queue_word(make_word(lts_pkg::FUNC_READ, 2'(k), 1'b0, 32'h0));
        for (k = 0; k < 40; k++)
            queue_word(pick_word());
        drain();
        repeat (10) @(negedge i_clk);

        if (mismatches == 0)
            $display("latency_threshold_statistics verification clean");
        else
            $display("latency_threshold_statistics verification failed");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #(20_000_000);
        $display("latency_threshold_statistics verification failed");
        $finish;
    end

endmodule
